// ----- rtl/vmt_pkg.sv -----
// ----------------------------------------------------------------------------
// vmt_pkg
// shared types, widths and codes for the 4x4 vertex transform engine
// ----------------------------------------------------------------------------
package vmt_pkg;

  localparam int DATA_W        = 32;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int PAIR_W        = PROD_W + 1;
  localparam int SUM_W         = PROD_W + 2;
  localparam int DIM           = 4;
  localparam int FRAC_BITS_DEF = 16;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // request kind
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_XFORM = 1'b1;

  localparam word_t SAT_MAX = word_t'(32'h7fff_ffff);
  localparam word_t SAT_MIN = word_t'(32'h8000_0000);

  // per-stage load enables handed to the lanes
  typedef struct packed {
    logic mul_en;
    logic pair_en;
    logic sum_en;
  } lane_ctl_t;

endpackage

// ----- rtl/vmt_lane.sv -----
// ----------------------------------------------------------------------------
// vmt_lane
// one matrix row dotted with the vector: products, pair sums, full sum
// ----------------------------------------------------------------------------
module vmt_lane (
  input  logic               clk,
  input  vmt_pkg::lane_ctl_t ctl,
  input  vmt_pkg::word_t     row_elem [vmt_pkg::DIM],
  input  vmt_pkg::word_t     vec      [vmt_pkg::DIM],
  output vmt_pkg::sum_t      sum
);
  import vmt_pkg::*;

  prod_t prod [DIM];
  pair_t pair [2];

  // stage 1: four full products
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      for (int k = 0; k < DIM; k++) begin
        prod[k] <= PROD_W'(row_elem[k]) * PROD_W'(vec[k]);
      end
    end
  end

  // stage 2: pair sums
  always_ff @(posedge clk) begin
    if (ctl.pair_en) begin
      pair[0] <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
      pair[1] <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
    end
  end

  // stage 3: exact row sum
  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      sum <= SUM_W'(pair[0]) + SUM_W'(pair[1]);
    end
  end

endmodule

// ----- rtl/vmt_merge.sv -----
// ----------------------------------------------------------------------------
// vmt_merge
// scales each lane sum, saturates to 32 bits and folds the clamp flags
// ----------------------------------------------------------------------------
module vmt_merge #(
  parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           en,
  input  vmt_pkg::sum_t  sum [vmt_pkg::DIM],
  output vmt_pkg::word_t res [vmt_pkg::DIM],
  output logic           clamped
);
  import vmt_pkg::*;

  sum_t  shifted [DIM];
  word_t res_next [DIM];
  logic  [DIM-1:0] sat;

  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      shifted[r] = sum[r] >>> FRAC_BITS;
      // fits when the result sign and all bits above it agree
      if ((&shifted[r][SUM_W-1:DATA_W-1]) || !(|shifted[r][SUM_W-1:DATA_W-1])) begin
        res_next[r] = shifted[r][DATA_W-1:0];
        sat[r]      = 1'b0;
      end else begin
        res_next[r] = shifted[r][SUM_W-1] ? SAT_MIN : SAT_MAX;
        sat[r]      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res     <= res_next;
      clamped <= |sat;
    end
  end

endmodule

// ----- rtl/vertex_matrix_transform.sv -----
// ----------------------------------------------------------------------------
// vertex_matrix_transform
// 4x4 homogeneous matrix times vector, signed fixed point, saturated output
// ----------------------------------------------------------------------------
//
//  channel   signals                                      direction
//  -------   -------------------------------------------  ---------
//  in        in_valid/in_ready, mode row col load_value,   sink
//            in_x in_y in_z in_w
//  out       out_valid/out_ready, out_x out_y out_z out_w, source
//            clamped
//
//  one request per cycle sustained while the output is ready; a transform
//  result is registered through multiply (at the accepting edge), pair add,
//  row add and scale/saturate before out_valid rises with it
//  load requests update the matrix at the accepting edge and give no result
//  rst clears pipeline valids and sets the matrix to identity
//  stalls ripple back stage by stage; empty stages are filled while the
//  output waits, so in_ready drops only when every stage holds a request
//
module vertex_matrix_transform #(
  parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           mode,
  input  logic [1:0]     row,
  input  logic [1:0]     col,
  input  vmt_pkg::word_t load_value,
  input  vmt_pkg::word_t in_x,
  input  vmt_pkg::word_t in_y,
  input  vmt_pkg::word_t in_z,
  input  vmt_pkg::word_t in_w,
  output logic           out_valid,
  input  logic           out_ready,
  output vmt_pkg::word_t out_x,
  output vmt_pkg::word_t out_y,
  output vmt_pkg::word_t out_z,
  output vmt_pkg::word_t out_w,
  output logic           clamped
);
  import vmt_pkg::*;

  localparam word_t ONE = word_t'(64'(1) << FRAC_BITS);

  // matrix held in flops, each row wired to its own lane
  word_t mtx [DIM][DIM];
  word_t vec [DIM];
  sum_t  lane_sum [DIM];
  word_t res [DIM];

  // pipeline valids
  logic v_mul, v_pair, v_sum;
  logic rdy_mul, rdy_pair, rdy_sum, rdy_out;
  logic accept;
  lane_ctl_t ctl;

  // per-stage handshake: a stage can load when empty or when it drains
  assign rdy_out  = !out_valid || out_ready;
  assign rdy_sum  = !v_sum  || rdy_out;
  assign rdy_pair = !v_pair || rdy_sum;
  assign rdy_mul  = !v_mul  || rdy_pair;
  assign in_ready = rdy_mul;
  assign accept   = in_valid && in_ready;

  assign ctl.mul_en  = accept && (mode == MODE_XFORM);
  assign ctl.pair_en = rdy_pair && v_mul;
  assign ctl.sum_en  = rdy_sum && v_pair;

  assign vec[0] = in_x;
  assign vec[1] = in_y;
  assign vec[2] = in_z;
  assign vec[3] = in_w;

  // matrix store, identity after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          mtx[r][c] <= (r == c) ? ONE : '0;
        end
      end
    end else if (accept && (mode == MODE_LOAD)) begin
      mtx[row][col] <= load_value;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul     <= 1'b0;
      v_pair    <= 1'b0;
      v_sum     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_mul)  v_mul     <= in_valid && (mode == MODE_XFORM);
      if (rdy_pair) v_pair    <= v_mul;
      if (rdy_sum)  v_sum     <= v_pair;
      if (rdy_out)  out_valid <= v_sum;
    end
  end

  // one lane per matrix row
  for (genvar r = 0; r < DIM; r++) begin : g_lane
    vmt_lane u_lane (
      .clk      (clk),
      .ctl      (ctl),
      .row_elem (mtx[r]),
      .vec      (vec),
      .sum      (lane_sum[r])
    );
  end

  // scale, saturate and register the result
  vmt_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk     (clk),
    .en      (rdy_out && v_sum),
    .sum     (lane_sum),
    .res     (res),
    .clamped (clamped)
  );

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];
  assign out_w = res[3];

endmodule

// ----- tb/sv/vmt_xform_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vmt_xform_checker
// watches both channels of the transform engine, keeps a shadow copy of the
// matrix, predicts every transform result and compares it field by field
// ----------------------------------------------------------------------------
module vmt_xform_checker
  import vmt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       mode,
  input  logic [1:0] row,
  input  logic [1:0] col,
  input  word_t      load_value,
  input  word_t      in_x,
  input  word_t      in_y,
  input  word_t      in_z,
  input  word_t      in_w,
  input  logic       out_valid,
  input  logic       out_ready,
  input  word_t      out_x,
  input  word_t      out_y,
  input  word_t      out_z,
  input  word_t      out_w,
  input  logic       clamped,
  output int         errors,
  output int         pending
);

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    word_t w;
    logic  clamped;
  } vertex_result_t;

  word_t          mat_shadow [DIM*DIM];
  vertex_result_t vertex_q [$];
  int             err_cnt = 0;

  initial begin
    errors  = 0;
    pending = 0;
  end

  // one row dot vector, floor shift, saturate; msb of the return is the clamp flag
  function automatic logic [DATA_W:0] row_dot_sat(input int r,
                                                 input word_t v0, v1, v2, v3);
    word_t vec [DIM];
    prod_t p;
    sum_t  acc;
    sum_t  scaled;
    vec[0] = v0;
    vec[1] = v1;
    vec[2] = v2;
    vec[3] = v3;
    acc = '0;
    for (int k = 0; k < DIM; k++) begin
      p   = mat_shadow[r*DIM + k] * vec[k];
      acc = acc + sum_t'(p);
    end
    scaled = acc >>> FRAC_BITS;
    if (scaled > sum_t'(SAT_MAX)) return {1'b1, SAT_MAX};
    if (scaled < sum_t'(SAT_MIN)) return {1'b1, SAT_MIN};
    return {1'b0, scaled[DATA_W-1:0]};
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want, got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : track
    vertex_result_t  want;
    logic [DATA_W:0] rx, ry, rz, rw;
    if (rst) begin
      for (int i = 0; i < DIM*DIM; i++)
        mat_shadow[i] = (i / DIM == i % DIM) ? word_t'(1 << FRAC_BITS) : '0;
      vertex_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (vertex_q.size() == 0) begin
          $error("result with none expected: %h %h %h %h clamped %b",
                 out_x, out_y, out_z, out_w, clamped);
          err_cnt++;
        end else begin
          want = vertex_q.pop_front();
          check_field("out_x", want.x, out_x);
          check_field("out_y", want.y, out_y);
          check_field("out_z", want.z, out_z);
          check_field("out_w", want.w, out_w);
          check_field("clamped", DATA_W'(want.clamped), DATA_W'(clamped));
        end
      end
      if (in_valid && in_ready) begin
        if (mode == MODE_LOAD) begin
          mat_shadow[{row, col}] = load_value;
        end else begin
          rx = row_dot_sat(0, in_x, in_y, in_z, in_w);
          ry = row_dot_sat(1, in_x, in_y, in_z, in_w);
          rz = row_dot_sat(2, in_x, in_y, in_z, in_w);
          rw = row_dot_sat(3, in_x, in_y, in_z, in_w);
          want.x       = rx[DATA_W-1:0];
          want.y       = ry[DATA_W-1:0];
          want.z       = rz[DATA_W-1:0];
          want.w       = rw[DATA_W-1:0];
          want.clamped = rx[DATA_W] | ry[DATA_W] | rz[DATA_W] | rw[DATA_W];
          vertex_q.push_back(want);
        end
      end
    end
    errors  <= err_cnt;
    pending <= vertex_q.size();
  end

endmodule

// ----- tb/sv/tb_vertex_matrix_transform.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vertex_matrix_transform
// drives load and transform requests into the 4x4 transform engine with
// random gaps and output stalls; a side checker predicts and compares
// ----------------------------------------------------------------------------
module tb_vertex_matrix_transform;
  import vmt_pkg::*;

  localparam int          FRAC_BITS = FRAC_BITS_DEF;
  // worst case is far below this: ~820 requests, each with a long gap and stall
  localparam int unsigned RUN_LIMIT = 500_000;
  localparam word_t       ONE       = word_t'(32'h0001_0000);
  localparam word_t       NEG_ONE   = word_t'(32'hffff_ffff);

  // clock and synchronous reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // request side, all known from time zero
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic       mode       = MODE_LOAD;
  logic [1:0] row        = '0;
  logic [1:0] col        = '0;
  word_t      load_value = '0;
  word_t      in_x       = '0;
  word_t      in_y       = '0;
  word_t      in_z       = '0;
  word_t      in_w       = '0;

  // result side
  logic  out_valid;
  logic  out_ready = 1'b0;
  word_t out_x, out_y, out_z, out_w;
  logic  clamped;

  // checker status
  int chk_errors;
  int chk_pending;

  // set while both sides should run without any idling
  bit full_rate = 1'b0;

  int unsigned cycle_cnt = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  vertex_matrix_transform #(
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .row        (row),
    .col        (col),
    .load_value (load_value),
    .in_x       (in_x),
    .in_y       (in_y),
    .in_z       (in_z),
    .in_w       (in_w),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .out_w      (out_w),
    .clamped    (clamped)
  );

  vmt_xform_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) u_chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .row        (row),
    .col        (col),
    .load_value (load_value),
    .in_x       (in_x),
    .in_y       (in_y),
    .in_z       (in_z),
    .in_w       (in_w),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .out_w      (out_w),
    .clamped    (clamped),
    .errors     (chk_errors),
    .pending    (chk_pending)
  );

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    if (full_rate) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // operand mix: some corner values, some full range, half of them small
  // (within about +-4.0) so that the sums mostly stay inside 32 bits
  function automatic word_t rand_word();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 4))
        0:       return SAT_MAX;
        1:       return SAT_MIN;
        2:       return '0;
        3:       return NEG_ONE;
        default: return ONE;
      endcase
    end
    if (sel < 5) return word_t'($urandom());
    return word_t'($urandom_range(0, 32'h0008_0000)) - word_t'(32'h0004_0000);
  endfunction

  // offer one request, optionally after an idle gap, and hold it until taken;
  // called at a rising edge and returns at the edge that accepted the request
  task automatic offer_req(input logic m, input logic [1:0] r, c,
                           input word_t lv, vx, vy, vz, vw);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    row        <= r;
    col        <= c;
    load_value <= lv;
    in_x       <= vx;
    in_y       <= vy;
    in_z       <= vz;
    in_w       <= vw;
    do @(posedge clk); while (!in_ready);
  endtask

  // load request: the vector fields carry junk the block must ignore
  task automatic load_elem(input logic [1:0] r, c, input word_t v);
    offer_req(MODE_LOAD, r, c, v, rand_word(), rand_word(), rand_word(), rand_word());
  endtask

  // transform request: row, col and load value carry junk as well
  task automatic xform_vec(input word_t vx, vy, vz, vw);
    offer_req(MODE_XFORM, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
              rand_word(), vx, vy, vz, vw);
  endtask

  // stop sending and hold off until every predicted result has come back;
  // the checker's count is registered, so look only after the next edge
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk_pending != 0);
  endtask

  // result side pacing: runs of ready broken by stalls of random length
  initial begin : sink_pacing
    int run_len;
    int stall;
    while (rst) @(posedge clk);
    forever begin
      run_len = $urandom_range(1, 20);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("tb_vertex_matrix_transform: errors");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // identity after reset passes the vector through
    xform_vec(ONE, ONE, ONE, ONE);
    // extreme components through identity, no clamping expected
    xform_vec(SAT_MAX, SAT_MIN, '0, NEG_ONE);
    // row 0 all max, row 1 all min, covering every column index
    for (int c = 0; c < DIM; c++) load_elem(2'd0, 2'(c), SAT_MAX);
    for (int c = 0; c < DIM; c++) load_elem(2'd1, 2'(c), SAT_MIN);
    // positive clamp on x, negative clamp on y
    xform_vec(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
    // signs flip: negative clamp on x, positive clamp on y (min times min)
    xform_vec(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
    // zero vector gives zero even with the extreme rows
    xform_vec('0, '0, '0, '0);
    // tiny elements: a product of -1 lsb must round down to -1, not to 0
    load_elem(2'd2, 2'd2, word_t'(1));
    load_elem(2'd3, 2'd3, NEG_ONE);
    xform_vec('0, '0, NEG_ONE, ONE);
    drain_results();

    // --- random part, four phases; the third runs with no idling at all ---
    for (int ph = 0; ph < 4; ph++) begin
      full_rate = (ph == 2);
      for (int i = 0; i < 200; i++) begin
        if ($urandom_range(0, 99) < 30)
          load_elem(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), rand_word());
        else
          xform_vec(rand_word(), rand_word(), rand_word(), rand_word());
      end
      // sender holds off until the pipeline is empty
      drain_results();
    end
    full_rate = 1'b0;

    // let any stray result surface after the last expected one
    repeat (12) @(posedge clk);

    if (chk_errors == 0 && chk_pending == 0) begin
      $display("tb_vertex_matrix_transform: clean");
    end else begin
      $display("tb_vertex_matrix_transform: errors");
    end
    $finish;
  end

endmodule
